// ----- src/spvc_pkg.sv -----
// Package for the solar pump and valve controller.
// Holds the transaction payload types, the controller state type and fixed codes.
// No dependencies; used by spvc_step and solar_pump_valve_controller.
`default_nettype none

package spvc_pkg;

  // Command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_POLL  = 2'd1,
    CMD_STORE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // View codes
  localparam logic [1:0] VIEW_TEMP = 2'd0;
  localparam logic [1:0] VIEW_LOW  = 2'd1;
  localparam logic [1:0] VIEW_HIGH = 2'd2;

  // Servo angles and counter limits
  localparam logic [6:0] ANGLE_OPEN   = 7'd120;
  localparam logic [6:0] ANGLE_CLOSED = 7'd0;
  localparam logic [7:0] TICKS_MAX    = 8'd255;
  localparam logic [6:0] SHOWN_MAX    = 7'd127;
  // Reciprocal of 10 in Q15, exact for 11-bit dividends
  localparam logic [11:0] RECIP_TEN   = 12'd3277;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               key_low_down;
    logic               key_high_down;
    logic               key_temp_down;
    logic               knob_button;
    logic signed [7:0]  knob_delta;
    logic               reading_valid;
    logic signed [11:0] reading_deci;
    logic [5:0]         stored_low;
    logic [5:0]         stored_high;
  } in_item_t;

  typedef struct packed {
    logic [1:0] view_now;
    logic [6:0] shown_value;
    logic       pump_on;
    logic       valve_is_open;
    logic [6:0] valve_angle;
    logic       save_request;
    logic [5:0] save_low;
    logic [5:0] save_high;
  } out_item_t;

  typedef struct packed {
    logic [5:0]         low_setpoint;
    logic [5:0]         high_setpoint;
    logic [5:0]         edit_value;
    logic [1:0]         view_mode;
    logic [2:0]         keys_before;
    logic               knob_before;
    logic [7:0]         hold_ticks;
    logic               hold_cancelled;
    logic signed [11:0] last_temp;
    logic               pump_state;
    logic               valve_state;
  } state_t;

endpackage

`default_nettype wire

// ----- src/solar_pump_valve_controller.sv -----
// Solar heating pump and valve controller, top level.
// Holds the input register, controller state and result register around spvc_step.
// Depends on spvc_pkg and spvc_step.
//
// Each input transaction (timer tick, service poll, stored setpoint report or no-op)
// yields exactly one result transaction that reports the view, the shown value,
// the pump and valve drives and any save request after that transaction. An
// item is held in the input register, then moves to the result register that
// drives the result port, and waits while the result side stalls; one item is
// accepted every cycle while the result side keeps up. The single combinational
// step lies between the input register and the result register. Setpoints start
// at zero and change only on a stored setpoint report; a committed edit is only offered as a save request.
`default_nettype none

module solar_pump_valve_controller #(
  parameter int DEGREE_LIMIT      = 60,
  parameter int HOLD_CANCEL_TICKS = 2
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire spvc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output spvc_pkg::out_item_t      out_data
);

  logic                 in_valid_r;
  spvc_pkg::in_item_t   in_data_r;
  spvc_pkg::state_t     state_r;
  spvc_pkg::state_t     state_nxt;
  spvc_pkg::out_item_t  result_nxt;
  spvc_pkg::out_item_t  out_data_r;
  logic                 out_valid_r;
  logic                 advance;
  logic                 load_in;

  // Move the held item into the result register when the result slot is free
  assign advance  = !out_valid_r || !out_stall;
  assign load_in  = !in_valid_r || advance;
  assign in_stall = !load_in;

  spvc_step #(
    .DEGREE_LIMIT      (DEGREE_LIMIT),
    .HOLD_CANCEL_TICKS (HOLD_CANCEL_TICKS)
  ) u_step (
    .state_i  (state_r),
    .item_i   (in_data_r),
    .state_o  (state_nxt),
    .result_o (result_nxt)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (load_in) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Controller state, updated as each item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.low_setpoint   <= 6'd0;
      state_r.high_setpoint  <= 6'd0;
      state_r.edit_value     <= 6'd0;
      state_r.view_mode      <= spvc_pkg::VIEW_TEMP;
      state_r.keys_before    <= 3'd0;
      state_r.knob_before    <= 1'b0;
      state_r.hold_ticks     <= 8'd0;
      state_r.hold_cancelled <= 1'b0;
      state_r.last_temp      <= 12'sd0;
      state_r.pump_state     <= 1'b0;
      state_r.valve_state    <= 1'b1;
    end else if (in_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- src/spvc_step.sv -----
// Combinational step of the controller: next state and result for one transaction.
// Depends on spvc_pkg for the payload and state types and codes.
`default_nettype none

module spvc_step #(
  parameter int DEGREE_LIMIT      = 60,
  parameter int HOLD_CANCEL_TICKS = 2
) (
  input  wire spvc_pkg::state_t    state_i,
  input  wire spvc_pkg::in_item_t  item_i,
  output spvc_pkg::state_t         state_o,
  output spvc_pkg::out_item_t      result_o
);

  localparam logic [5:0]        DEG_LIM   = 6'(DEGREE_LIMIT);
  localparam logic signed [9:0] DEG_LIM_S = 10'(DEGREE_LIMIT);
  localparam logic [7:0]        HOLD_LIM  = 8'(HOLD_CANCEL_TICKS);

  spvc_pkg::state_t   st;
  logic [2:0]         keys;
  logic [2:0]         key_edge;
  logic               save;
  logic [5:0]         s_low;
  logic [5:0]         s_high;
  logic signed [9:0]  edit_sum;
  logic signed [12:0] low_deci;
  logic signed [12:0] high_deci;
  logic signed [12:0] temp_ext;
  logic [22:0]        prod;
  logic [7:0]         quo;
  logic [6:0]         shown;

  // Apply one transaction in the order poll handling requires
  always_comb begin
    st       = state_i;
    save     = 1'b0;
    s_low    = 6'd0;
    s_high   = 6'd0;
    keys     = {item_i.key_temp_down, item_i.key_high_down, item_i.key_low_down};
    key_edge = keys & ~state_i.keys_before;
    edit_sum  = '0;
    low_deci  = 13'(state_i.low_setpoint) * 13'sd10;
    high_deci = 13'(state_i.high_setpoint) * 13'sd10;
    temp_ext  = {item_i.reading_deci[11], item_i.reading_deci};

    unique case (spvc_pkg::cmd_t'(item_i.cmd))
      spvc_pkg::CMD_TICK: begin
        // count button hold time inside an edit view
        if (st.knob_before && st.view_mode != spvc_pkg::VIEW_TEMP &&
            st.hold_ticks < spvc_pkg::TICKS_MAX) begin
          st.hold_ticks = st.hold_ticks + 8'd1;
        end
      end
      spvc_pkg::CMD_POLL: begin
        // key press edges, low then high then temperature
        if (key_edge[0]) begin
          st.view_mode      = spvc_pkg::VIEW_LOW;
          st.edit_value     = st.low_setpoint;
          st.hold_ticks     = 8'd0;
          st.hold_cancelled = 1'b0;
        end
        if (key_edge[1]) begin
          st.view_mode      = spvc_pkg::VIEW_HIGH;
          st.edit_value     = st.high_setpoint;
          st.hold_ticks     = 8'd0;
          st.hold_cancelled = 1'b0;
        end
        if (key_edge[2]) begin
          st.view_mode      = spvc_pkg::VIEW_TEMP;
          st.hold_ticks     = 8'd0;
          st.hold_cancelled = 1'b0;
        end
        st.keys_before = keys;

        // knob button press restarts the hold, release commits the edit
        if (st.view_mode != spvc_pkg::VIEW_TEMP) begin
          if (item_i.knob_button && !st.knob_before) begin
            st.hold_ticks     = 8'd0;
            st.hold_cancelled = 1'b0;
          end else if (!item_i.knob_button && st.knob_before && !st.hold_cancelled) begin
            save = 1'b1;
            if (st.view_mode == spvc_pkg::VIEW_LOW) begin
              s_low  = st.edit_value;
              s_high = st.high_setpoint;
            end else begin
              s_low  = st.low_setpoint;
              s_high = st.edit_value;
            end
            st.view_mode      = spvc_pkg::VIEW_TEMP;
            st.hold_ticks     = 8'd0;
            st.hold_cancelled = 1'b0;
          end
        end
        st.knob_before = item_i.knob_button;

        // long hold abandons the edit; leaving the view clears the hold again
        if (item_i.knob_button && st.view_mode != spvc_pkg::VIEW_TEMP &&
            st.hold_ticks >= HOLD_LIM && !st.hold_cancelled) begin
          st.view_mode      = spvc_pkg::VIEW_TEMP;
          st.hold_ticks     = 8'd0;
          st.hold_cancelled = 1'b0;
        end

        // knob turn, clamped to the setpoint range
        if (st.view_mode != spvc_pkg::VIEW_TEMP && item_i.knob_delta != 8'sd0) begin
          edit_sum = $signed({4'b0000, st.edit_value}) +
                     $signed({{2{item_i.knob_delta[7]}}, item_i.knob_delta});
          if (edit_sum < 10'sd0) begin
            st.edit_value = 6'd0;
          end else if (edit_sum > DEG_LIM_S) begin
            st.edit_value = DEG_LIM;
          end else begin
            st.edit_value = edit_sum[5:0];
          end
        end

        // hysteresis on a valid reading
        if (item_i.reading_valid) begin
          st.last_temp = item_i.reading_deci;
          if (temp_ext < low_deci) begin
            st.pump_state  = 1'b0;
            st.valve_state = 1'b1;
          end else if (temp_ext > high_deci) begin
            st.valve_state = 1'b0;
            st.pump_state  = 1'b1;
          end
        end
      end
      spvc_pkg::CMD_STORE: begin
        st.low_setpoint  = item_i.stored_low;
        st.high_setpoint = item_i.stored_high;
      end
      spvc_pkg::CMD_NOP: begin
        st = state_i;
      end
      default: begin
        st = state_i;
      end
    endcase
  end

  // Edit value or whole degrees of kept reading by reciprocal multiply, saturated
  always_comb begin
    prod  = {12'd0, st.last_temp[10:0]} * {11'd0, spvc_pkg::RECIP_TEN};
    quo   = prod[22:15];
    shown = 7'd0;
    if (st.view_mode != spvc_pkg::VIEW_TEMP) begin
      shown = {1'b0, st.edit_value};
    end else if (st.last_temp > 12'sd0) begin
      shown = (quo > 8'(spvc_pkg::SHOWN_MAX)) ? spvc_pkg::SHOWN_MAX : quo[6:0];
    end
  end

  // Drive next state and result
  always_comb begin
    state_o                = st;
    result_o.view_now      = st.view_mode;
    result_o.shown_value   = shown;
    result_o.pump_on       = st.pump_state;
    result_o.valve_is_open = st.valve_state;
    result_o.valve_angle   = st.valve_state ? spvc_pkg::ANGLE_OPEN : spvc_pkg::ANGLE_CLOSED;
    result_o.save_request  = save;
    result_o.save_low      = s_low;
    result_o.save_high     = s_high;
  end

endmodule

`default_nettype wire
